@@ sv/scf_pkg.sv @@
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants
// Widths, commands and controller states for the spectral centroid block.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 2 * SAMPLE_W + 1;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int WSUM_W   = 34;
    localparam int MSUM_W   = 25;
    localparam int BW_W     = 24;
    localparam int OUT_W    = 26;
    localparam int DIFF_W   = WSUM_W + 2;
    localparam int NUM_W    = DIFF_W + BW_W;
    localparam int DEN_W    = MSUM_W + 9;
    localparam int QUO_W    = NUM_W;
    localparam int SQRT_STEPS = (SQ_W + 1) / 2;
    localparam logic [BW_W-1:0] BW_RESET = 24'd6144000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_ACC,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic acc;
        logic prep;
        logic mul;
        logic div_start;
        logic div_step;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic last;
    } status_t;

endpackage

@@ sv/scf_datapath.sv @@
// ----------------------------------------------------------------------------
// scf_datapath: magnitude, accumulators and centroid divider
// Bit-serial square root, saturating sums, one multiply, restoring divide.
// ----------------------------------------------------------------------------
module scf_datapath #(
    parameter int HALF_BINS = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scf_pkg::cmd_t                 cmd,
    output scf_pkg::status_t              status,
    input  logic signed [scf_pkg::SAMPLE_W-1:0] real_part,
    input  logic signed [scf_pkg::SAMPLE_W-1:0] imag_part,
    input  logic                          last,
    input  logic [scf_pkg::BW_W-1:0]      bin_width,
    output logic signed [scf_pkg::OUT_W-1:0] centroid
);
    import scf_pkg::*;

    localparam int IDX_W = $clog2(HALF_BINS);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(HALF_BINS - 1);
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [2*SQRT_STEPS-1:0] rem_reg;
    logic [MAG_W-1:0]  root_reg;
    logic [$clog2(SQRT_STEPS+1)-1:0] sq_cnt_reg;
    logic              last_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [MSUM_W-1:0] msum_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              neg_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    drem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              inexact_reg;
    logic [CNT_W-1:0]  dcnt_reg;

    logic [SAMPLE_W:0] are, aim;
    logic [SQ_W-1:0]   sq;
    assign are = real_part[SAMPLE_W-1] ? -{real_part[SAMPLE_W-1], real_part}
                                       :  {real_part[SAMPLE_W-1], real_part};
    assign aim = imag_part[SAMPLE_W-1] ? -{imag_part[SAMPLE_W-1], imag_part}
                                       :  {imag_part[SAMPLE_W-1], imag_part};
    assign sq  = SQ_W'(are * are) + SQ_W'(aim * aim);

    // one root bit per step, two remainder bits in
    logic [2*SQRT_STEPS-1:0] sq_bits;
    logic [MAG_W+1:0]  trial;
    logic [MAG_W+1:0]  part;
    logic [$clog2(SQRT_STEPS+1)-1:0] sh;
    always_comb begin
        sh      = sq_cnt_reg;
        sq_bits = rem_reg;
        part    = '0;
        trial   = {root_reg, 2'b01};
        part    = (MAG_W+2)'(sq_bits >> (2 * (SQRT_STEPS - 1)));
    end

    // divider compare
    logic [DEN_W:0] dsh;
    logic [DEN_W:0] dsub;
    assign dsh  = {drem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign dsub = dsh - {1'b0, den_reg};

    // magnitude of the signed difference ahead of the multiply
    logic [DIFF_W-1:0] adiff;
    assign adiff = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);

    logic [WSUM_W+IDX_W-1:0] prod;
    logic [WSUM_W:0] wadd;
    logic [MSUM_W:0] madd;
    assign prod = idx_reg * root_reg;
    assign wadd = {1'b0, wsum_reg} + (WSUM_W+1)'(prod);
    assign madd = {1'b0, msum_reg} + (MSUM_W+1)'(root_reg);

    // root and remainder have separate registers: rem holds the shifted radicand
    logic [MAG_W+1:0] acc_rem;
    logic [MAG_W+1:0] rmd_reg;
    logic [MAG_W+1:0] rmd_sh;
    assign rmd_sh  = {rmd_reg[MAG_W-1:0], part[1:0]};
    assign acc_rem = rmd_sh - trial;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg    <= (2*SQRT_STEPS)'(sq);
            root_reg   <= '0;
            rmd_reg    <= '0;
            sq_cnt_reg <= '0;
            last_reg   <= last;
        end else if (cmd.sqrt_step) begin
            rem_reg    <= rem_reg << 2;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (!acc_rem[MAG_W+1]) begin
                rmd_reg  <= acc_rem;
                root_reg <= {root_reg[MAG_W-2:0], 1'b1};
            end else begin
                rmd_reg  <= rmd_sh;
                root_reg <= {root_reg[MAG_W-2:0], 1'b0};
            end
        end
        if (!aresetn || cmd.clear) begin
            idx_reg  <= '0;
            wsum_reg <= '0;
            msum_reg <= '0;
        end else if (cmd.acc) begin
            wsum_reg <= (wadd[WSUM_W] || prod[WSUM_W+IDX_W-1:WSUM_W] != '0) ? '1
                                                             : wadd[WSUM_W-1:0];
            msum_reg <= madd[MSUM_W] ? '1 : madd[MSUM_W-1:0];
            if (idx_reg != IDX_MAX) idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.prep) begin
            den_reg  <= {(msum_reg == '0) ? MSUM_W'(1) : msum_reg, 9'd0};
            diff_reg <= $signed({2'b00, wsum_reg} << 1)
                      - $signed({{(DIFF_W-MSUM_W){1'b0}},
                                 (msum_reg == '0) ? MSUM_W'(1) : msum_reg});
        end
        if (cmd.mul) begin
            neg_reg <= diff_reg[DIFF_W-1];
            num_reg <= NUM_W'(adiff) * NUM_W'(bin_width);
        end
        if (cmd.div_start) begin
            drem_reg    <= '0;
            quo_reg     <= '0;
            dcnt_reg    <= '0;
            inexact_reg <= 1'b0;
        end else if (cmd.div_step) begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!dsub[DEN_W]) begin
                drem_reg <= dsub;
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                drem_reg <= dsh;
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign status.sqrt_done = (sq_cnt_reg == ($clog2(SQRT_STEPS+1))'(SQRT_STEPS));
    assign status.div_done  = (dcnt_reg == CNT_W'(QUO_W));
    assign status.last      = last_reg;

    // floor for negative quotients, then saturate
    logic signed [QUO_W+1:0] q;
    always_comb begin
        q = $signed({2'b00, quo_reg});
        if (neg_reg) q = -q - ((drem_reg != '0) ? 1 : 0);
        if (q > $signed((QUO_W+2)'(33554431)))
            centroid = {1'b0, {(OUT_W-1){1'b1}}};
        else if (q < -$signed((QUO_W+2)'(33554432)))
            centroid = {1'b1, {(OUT_W-1){1'b0}}};
        else
            centroid = q[OUT_W-1:0];
    end

    logic unused;
    assign unused = ^{sh, inexact_reg, part[MAG_W+1:2]};
endmodule

@@ sv/scf_ctrl.sv @@
// ----------------------------------------------------------------------------
// scf_ctrl: sequencing controller
// Steps the root per bin and the divider per frame, drives the handshakes.
// ----------------------------------------------------------------------------
module scf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output scf_pkg::cmd_t     cmd,
    input  scf_pkg::status_t  status
);
    import scf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SQRT;
            ST_SQRT: if (status.sqrt_done) state_next = ST_ACC;
            ST_ACC:  state_next = status.last ? ST_PREP : ST_IDLE;
            ST_PREP: state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (status.div_done) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SQRT: cmd.sqrt_step = !status.sqrt_done;
            ST_ACC:  cmd.acc = 1'b1;
            ST_PREP: cmd.prep = 1'b1;
            ST_MUL: begin
                cmd.mul       = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIV:  cmd.div_step = !status.div_done;
            ST_OUT: begin
                m_valid   = 1'b1;
                cmd.clear = m_ready;
            end
            default: ;
        endcase
    end
endmodule

@@ sv/spectral_centroid_frame.sv @@
// ----------------------------------------------------------------------------
// spectral_centroid_frame: spectral centroid over one half-spectrum frame
// Magnitude per bin, weighted and plain sums, one divide per frame.
// ----------------------------------------------------------------------------
// Input channel s_*: one FFT bin per transaction, s_last on the final bin.
// Result channel m_*: one centroid per frame in Hz, signed Q.8.
// bin_width is to be written through cfg_we / cfg_data only while the block is
// idle; the block itself does not enforce this. Each bin is loaded, run
// for 17 steps of the bit-serial root unit until it reports done, then
// accumulated. The last bin adds prepare, multiply and a restoring divide
// before m_valid rises. Bins of the next frame are taken once the result
// transaction is done. Reset clears the sums, the bin index and the
// controller and loads bin_width with 93.75 Hz. While m_ready is low the
// result holds on m_centroid_hz_q8 and no new bin is taken.
// ----------------------------------------------------------------------------
module spectral_centroid_frame #(
    parameter int HALF_BINS = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_real_part,
    input  logic signed [15:0] s_imag_part,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [25:0] m_centroid_hz_q8
);
    import scf_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [BW_W-1:0] bin_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)    bin_width_reg <= BW_RESET;
        else if (cfg_we) bin_width_reg <= cfg_data;
    end

    scf_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .status
    );

    scf_datapath #(.HALF_BINS(HALF_BINS)) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .real_part (s_real_part),
        .imag_part (s_imag_part),
        .last      (s_last),
        .bin_width (bin_width_reg),
        .centroid  (m_centroid_hz_q8)
    );
endmodule

@@ bench/spectral_centroid_frame_tb.sv @@
// ----------------------------------------------------------------------------
// spectral_centroid_frame_tb: self-checking bench for the centroid block
// Directed frames from a stimulus table, then random frames, with random
// idling on both channels and a long result stall. Each centroid is checked
// against a typed table value or a predictor keeping its own sums and width.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spectral_centroid_frame_tb;
    import scf_pkg::*;

    localparam int HALF_BINS = 512;
    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [33:0] WSUM_SAT = {34{1'b1}};
    localparam logic [24:0] MSUM_SAT = {25{1'b1}};
    localparam logic signed [63:0] CEN_MAX = 64'sd33554431;
    localparam logic signed [63:0] CEN_MIN = -64'sd33554432;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
        logic               typed;   // expected value typed in below
        logic signed [25:0] cen;
    } bin_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [23:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_real_part = '0;
    logic signed [15:0] s_imag_part = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [25:0] m_centroid_hz_q8;

    spectral_centroid_frame #(.HALF_BINS(HALF_BINS)) uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_real_part(s_real_part),
        .s_imag_part(s_imag_part), .s_last(s_last), .m_valid(m_valid),
        .m_ready(m_ready), .m_centroid_hz_q8(m_centroid_hz_q8)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [23:0] bw_model;
    logic [9:0]  idx_model;
    logic [33:0] wsum_model;
    logic [24:0] msum_model;

    logic signed [25:0] centroid_q[$];
    int errors = 0;
    int frames_seen = 0;
    int bins_sent = 0;
    int cycles = 0;
    bit long_hold = 0;
    bit stim_done = 0;

    function automatic logic [16:0] floor_root(logic [32:0] x);
        logic [16:0] r;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            r[b] = 1'b1;
            if ({17'd0, r} * r > x) r[b] = 1'b0;
        end
        return r;
    endfunction

    // accumulate one bin; returns 1 with the centroid when the frame closes
    function automatic bit centroid_step(logic signed [15:0] re, logic signed [15:0] im,
                                         logic lst, output logic signed [25:0] cen);
        logic [16:0] are, aim, mag;
        logic [63:0] prod, wn, mn;
        logic signed [63:0] m, num, den, q;
        are = re < 0 ? -{re[15], re} : {1'b0, re};
        aim = im < 0 ? -{im[15], im} : {1'b0, im};
        mag = floor_root({16'd0, are} * are + {16'd0, aim} * aim);
        prod = 64'(idx_model) * mag;
        wn = 64'(wsum_model) + prod;
        mn = 64'(msum_model) + mag;
        wsum_model = wn > 64'(WSUM_SAT) ? WSUM_SAT : wn[33:0];
        msum_model = mn > 64'(MSUM_SAT) ? MSUM_SAT : mn[24:0];
        if (idx_model < HALF_BINS - 1) idx_model++;
        cen = '0;
        if (!lst) return 0;
        m = msum_model == 0 ? 64'sd1 : $signed(64'(msum_model));
        num = $signed(64'(bw_model)) * (2 * $signed(64'(wsum_model)) - m);
        den = m * 512;
        q = num / den;
        if (num % den != 0 && num < 0) q -= 1;
        if (q > CEN_MAX) q = CEN_MAX;
        if (q < CEN_MIN) q = CEN_MIN;
        cen = q[25:0];
        idx_model = '0;
        wsum_model = '0;
        msum_model = '0;
        return 1;
    endfunction

    task automatic send_bin(logic signed [15:0] re, logic signed [15:0] im, logic lst,
                            bit hold_exp, logic signed [25:0] typed_cen);
        logic signed [25:0] cen;
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_real_part <= re;
        s_imag_part <= im;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        bins_sent++;
        if (centroid_step(re, im, lst, cen)) begin
            if (hold_exp && cen !== typed_cen)
                $display("%0t: table row disagrees: typed %0d predicted %0d",
                         $time, typed_cen, cen);
            centroid_q.push_back(hold_exp ? typed_cen : cen);
        end
    endtask

    task automatic write_width(logic [23:0] w);
        s_valid <= 1'b0;
        while (centroid_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bw_model = w;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $signed(16'($urandom_range(0, 15)) - 16'd8);
            default: return $signed(16'($urandom));
        endcase
    endfunction

    // receiver: random stalls, and one long hold while frames keep coming
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 0;
            end
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (centroid_q.size() == 0) begin
                $display("%0t: unexpected centroid %0d", $time, m_centroid_hz_q8);
                errors++;
            end else begin
                if (m_centroid_hz_q8 !== centroid_q[0]) begin
                    $display("%0t: centroid mismatch: expected %0d actual %0d",
                             $time, centroid_q[0], m_centroid_hz_q8);
                    errors++;
                end
                void'(centroid_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("spectral_centroid_frame_tb failed");
            $finish;
        end
    end

    bin_row_t dir_tab[] = '{
        // all-zero frame gives minus half the bin width
        '{16'sd0, 16'sd0, 1'b1, 1'b1, -26'sd12000},
        '{16'sd0, 16'sd0, 1'b0, 1'b0, 26'sd0},
        '{16'sd0, 16'sd0, 1'b1, 1'b1, -26'sd12000},
        // one bin at index 0 with energy: same answer
        '{16'sd100, 16'sd0, 1'b1, 1'b1, -26'sd12000},
        '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, 26'sd0},
        '{16'sd32767, 16'sd32767, 1'b0, 1'b0, 26'sd0},
        '{-16'sd32768, 16'sd32767, 1'b1, 1'b0, 26'sd0},
        '{16'sd0, 16'sd3, 1'b0, 1'b0, 26'sd0},
        '{16'sd4, 16'sd0, 1'b0, 1'b0, 26'sd0},
        '{-16'sd3, -16'sd4, 1'b1, 1'b0, 26'sd0},
        '{16'sd1, -16'sd1, 1'b0, 1'b0, 26'sd0},
        '{16'sd32767, -16'sd32768, 1'b1, 1'b0, 26'sd0}
    };

    task automatic random_frame(int len, bit loud);
        for (int i = 0; i < len; i++) begin
            if (loud)
                send_bin(16'sh8000, 16'sh8000, i == len - 1, 0, '0);
            else
                send_bin(rand_sample(), rand_sample(), i == len - 1, 0, '0);
        end
    endtask

    initial begin
        bw_model = BW_RESET;
        idx_model = '0;
        wsum_model = '0;
        msum_model = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_bin(dir_tab[i].re, dir_tab[i].im, dir_tab[i].last,
                     dir_tab[i].typed, dir_tab[i].cen);

        // width extremes; a long frame past the index ceiling saturates msum
        write_width(24'hffffff);
        random_frame(3, 0);
        random_frame(800, 1);
        write_width(24'd0);
        random_frame(4, 0);
        write_width(24'd1);
        random_frame(2, 0);

        // stall the result side while the next frame's bins wait at the input
        write_width(24'($urandom));
        long_hold = 1;
        random_frame(5, 0);
        random_frame(5, 0);
        random_frame(5, 0);

        for (int ph = 0; ph < 4; ph++) begin
            write_width(ph == 3 ? BW_RESET : 24'($urandom));
            while (bins_sent < 240 * (ph + 1) + 660)
                random_frame($urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 12), 0);
        end

        s_valid <= 1'b0;
        while (centroid_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("%0d bins over %0d frames, widths at both extremes, one long stall",
                 bins_sent, frames_seen);
        if (errors == 0)
            $display("spectral_centroid_frame_tb passed");
        else
            $display("spectral_centroid_frame_tb failed");
        $finish;
    end

endmodule
